// File: sv/glide_altitude_accumulator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the glide altitude accumulator
// Concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef GLIDE_ALTITUDE_ACCUMULATOR_ASSERT_SVH
`define GLIDE_ALTITUDE_ACCUMULATOR_ASSERT_SVH

// Assertion that is switched off while the reset is high.
`define GAA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("glide altitude accumulator assertion failed");

// Assertion that is also checked while the reset is high.
`define GAA_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("glide altitude accumulator reset assertion failed");

`endif

// File: sv/gaa_pkg.sv
// ----------------------------------------------------------------------------
// Glide altitude accumulator package
// Shared types, register indexes, action codes and constants.
// ----------------------------------------------------------------------------
package gaa_pkg;

   localparam int ACTION_W    = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int RATIO_W     = 16;
   localparam int BANK_W      = 2;
   localparam int DIST_W      = 32;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_GLIDE_RATIO = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BANK_SEL    = 2'd1;

   localparam logic [RATIO_W-1:0] GLIDE_RATIO_RESET = 16'd4352;
   localparam logic [BANK_W-1:0]  BANK_SEL_RESET    = 2'd0;

   // Action codes.
   localparam logic [ACTION_W-1:0] ACT_START    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_TURN     = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_STRAIGHT = 2'd2;

   // Bank angle codes.
   localparam logic [BANK_W-1:0] BANK_20 = 2'd0;
   localparam logic [BANK_W-1:0] BANK_30 = 2'd1;

   // Cosines in unsigned Q0.16, and one in the same scale for straight flight.
   localparam logic [31:0] COS20_Q16 = 32'd61583;
   localparam logic [31:0] COS30_Q16 = 32'd56756;
   localparam logic [31:0] COS45_Q16 = 32'd46341;
   localparam logic [31:0] ONE_Q16   = 32'h0001_0000;

   // Iteration counts of the shared compare-subtract unit.
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 56;
   localparam int CNT_W      = 6;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIFF,
      S_MULX,
      S_MULY,
      S_MULR,
      S_SUM,
      S_SQRT,
      S_DIVI,
      S_DIV,
      S_ALT,
      S_DONE
   } state_type;

   // Operand selection for the shared units.
   typedef struct packed {
      logic mul_sel_x;
      logic mul_sel_y;
      logic mul_sel_ratio;
      logic sub_sel_sqrt;
   } unit_ctrl_type;

endpackage

// File: sv/gaa_channels_if.sv
// ----------------------------------------------------------------------------
// Glide altitude accumulator channels
// Valid/ready interfaces for points, results and register writes.
// ----------------------------------------------------------------------------
interface gaa_req_if #(parameter int COORD_WIDTH = 32);
   import gaa_pkg::*;
   logic                          valid;
   logic                          ready;
   logic [ACTION_W-1:0]           action;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic signed [COORD_WIDTH-1:0] entry_altitude;
   modport source (output valid, action, point_x, point_y, entry_altitude, input ready);
   modport sink   (input valid, action, point_x, point_y, entry_altitude, output ready);
endinterface

interface gaa_rsp_if #(parameter int COORD_WIDTH = 32);
   import gaa_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] altitude;
   logic [DIST_W-1:0]             distance_step;
   modport source (output valid, altitude, distance_step, input ready);
   modport sink   (input valid, altitude, distance_step, output ready);
endinterface

interface gaa_csr_if;
   import gaa_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/gaa_mult.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 32 by 32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module gaa_mult (
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   output logic [63:0] product
);
   logic [63:0] product_ff;
   logic [63:0] product_in;

   assign product_in = 64'(op_a) * 64'(op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;
endmodule

// File: sv/gaa_cmpsub.sv
// ----------------------------------------------------------------------------
// Shared compare-subtract unit
// One 64-bit subtraction that yields the difference and a no-borrow flag.
// ----------------------------------------------------------------------------
module gaa_cmpsub (
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        a_ge_b,
   output logic [63:0] diff
);
   logic [64:0] wide;

   assign wide   = {1'b0, op_a} - {1'b0, op_b};
   assign a_ge_b = ~wide[64];
   assign diff   = wide[63:0];
endmodule

// File: sv/glide_altitude_accumulator.sv
// ----------------------------------------------------------------------------
// Glide altitude accumulator
// Measures the horizontal step between trajectory points and lowers the
// altitude by the step divided by the (bank-scaled) glide ratio.
// ----------------------------------------------------------------------------
// Usage: points arrive on req_chan, one result per point leaves on rsp_chan,
// and csr_chan writes the glide ratio (index 0) and bank angle (index 1).
// Register writes are always taken and should be made while the block idles.
// A start point or an unknown action goes straight from idle to the output
// state, which loads its result. A turn or straight point steps through
// difference, the multiplier steps for x, y and the ratio, sum, the root
// steps (SQRT_STEPS), division setup, the division steps (DIV_STEPS),
// altitude and output. A saturated distance skips the root; a zero ratio
// skips the division. req_chan.ready is high only while no point is in
// progress, so the block takes the next point only once a result is loaded.
// The result sits in an output register, so the next point may be taken
// while it waits; that point then holds in its last cycle until the
// receiver takes the earlier result. Reset clears the previous point, the
// altitude, both registers to their defaults and any pending result.
// ----------------------------------------------------------------------------
module glide_altitude_accumulator #(
   parameter int COORD_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   gaa_req_if.sink    req_chan,
   gaa_rsp_if.source  rsp_chan,
   gaa_csr_if.sink    csr_chan
);
   import gaa_pkg::*;

   localparam int ALT_W = 66;
   localparam logic signed [ALT_W-1:0] ALT_HI = (ALT_W'(1) <<< (COORD_WIDTH - 1)) - ALT_W'(1);
   localparam logic signed [ALT_W-1:0] ALT_LO = -ALT_HI - ALT_W'(1);

   state_type state_ff, state_in;
   unit_ctrl_type ctrl;

   logic [RATIO_W-1:0]     glide_ratio_ff, glide_ratio_in;
   logic [BANK_W-1:0]      bank_sel_ff, bank_sel_in;
   logic [COORD_WIDTH-1:0] prev_x_ff, prev_x_in;
   logic [COORD_WIDTH-1:0] prev_y_ff, prev_y_in;
   logic [COORD_WIDTH-1:0] cur_alt_ff, cur_alt_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [COORD_WIDTH-1:0] pt_x_ff, pt_x_in;
   logic [COORD_WIDTH-1:0] pt_y_ff, pt_y_in;
   logic                   turn_ff, turn_in;
   logic [31:0]            ax_ff, ax_in;
   logic [31:0]            ay_ff, ay_in;
   logic                   big_ff, big_in;
   logic [64:0]            sum_ff, sum_in;
   logic [31:0]            ratio_ff, ratio_in;
   logic [63:0]            rem_ff, rem_in;
   logic [63:0]            root_ff, root_in;
   logic [63:0]            bit_ff, bit_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [DIST_W-1:0]      dist_ff, dist_in;
   logic [31:0]            drem_ff, drem_in;
   logic [55:0]            dq_ff, dq_in;
   logic [COORD_WIDTH-1:0] rsp_alt_ff, rsp_alt_in;
   logic [DIST_W-1:0]      rsp_dist_ff, rsp_dist_in;

   logic req_fire, csr_fire, rsp_free;
   logic [31:0] mul_a, mul_b, cos_val;
   logic [63:0] mul_q;
   logic [63:0] sub_a, sub_b, sub_diff;
   logic        sub_ge;

   logic [COORD_WIDTH:0]   dx, dy, nx, ny;
   logic [63:0]            magx, magy;
   logic [57:0]            drop;
   logic signed [ALT_W-1:0] alt_wide;
   logic [COORD_WIDTH-1:0] alt_sat;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_fire = csr_chan.valid && csr_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.altitude      = rsp_alt_ff;
   assign rsp_chan.distance_step = rsp_dist_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_chan.action) inside
                  ACT_TURN, ACT_STRAIGHT: state_in = S_DIFF;
                  default:                state_in = S_DONE;
               endcase
            end
         end
         S_DIFF: state_in = S_MULX;
         S_MULX: state_in = S_MULY;
         S_MULY: state_in = S_MULR;
         S_MULR: state_in = S_SUM;
         S_SUM:  state_in = (big_ff || sum_ff[64]) ? S_DIVI : S_SQRT;
         S_SQRT: state_in = (cnt_ff == CNT_W'(1)) ? S_DIVI : S_SQRT;
         S_DIVI: state_in = (ratio_ff == '0) ? S_ALT : S_DIV;
         S_DIV:  state_in = (cnt_ff == CNT_W'(1)) ? S_ALT : S_DIV;
         S_ALT:  state_in = S_DONE;
         S_DONE: state_in = rsp_free ? S_IDLE : S_DONE;
         default: state_in = S_IDLE;
      endcase
   end

   // Operand selection for the shared units.
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         S_MULX:  ctrl.mul_sel_x = 1'b1;
         S_MULY:  ctrl.mul_sel_y = 1'b1;
         S_MULR:  ctrl.mul_sel_ratio = 1'b1;
         S_SQRT:  ctrl.sub_sel_sqrt = 1'b1;
         default: ctrl = '0;
      endcase
   end

   always_comb begin
      case (bank_sel_ff)
         BANK_20: cos_val = COS20_Q16;
         BANK_30: cos_val = COS30_Q16;
         default: cos_val = COS45_Q16;
      endcase
   end

   always_comb begin
      if (ctrl.mul_sel_ratio) begin
         mul_a = 32'(glide_ratio_ff);
         mul_b = turn_ff ? cos_val : ONE_Q16;
      end else if (ctrl.mul_sel_y) begin
         mul_a = ay_ff;
         mul_b = ay_ff;
      end else if (ctrl.mul_sel_x) begin
         mul_a = ax_ff;
         mul_b = ax_ff;
      end else begin
         mul_a = '0;
         mul_b = '0;
      end
   end

   // The root never overlaps the trial bit, so an OR forms root + bit.
   always_comb begin
      if (ctrl.sub_sel_sqrt) begin
         sub_a = rem_ff;
         sub_b = root_ff | bit_ff;
      end else begin
         sub_a = {31'b0, drem_ff, dq_ff[55]};
         sub_b = {32'b0, ratio_ff};
      end
   end

   gaa_mult u_gaa_mult (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_q)
   );

   gaa_cmpsub u_gaa_cmpsub (
      .op_a   (sub_a),
      .op_b   (sub_b),
      .a_ge_b (sub_ge),
      .diff   (sub_diff)
   );

   // Absolute coordinate differences; anything of 2^32 or more saturates.
   assign dx   = {pt_x_ff[COORD_WIDTH-1], pt_x_ff} - {prev_x_ff[COORD_WIDTH-1], prev_x_ff};
   assign dy   = {pt_y_ff[COORD_WIDTH-1], pt_y_ff} - {prev_y_ff[COORD_WIDTH-1], prev_y_ff};
   assign nx   = dx[COORD_WIDTH] ? (~dx + 1'b1) : dx;
   assign ny   = dy[COORD_WIDTH] ? (~dy + 1'b1) : dy;
   assign magx = 64'(nx[COORD_WIDTH-1:0]);
   assign magy = 64'(ny[COORD_WIDTH-1:0]);

   // A zero ratio drops the altitude by more than any range can hold.
   assign drop     = (ratio_ff == '0) ? (58'(1) << 57) : {2'b0, dq_ff};
   assign alt_wide = $signed({{(ALT_W - COORD_WIDTH){cur_alt_ff[COORD_WIDTH-1]}}, cur_alt_ff})
                   - $signed({8'b0, drop});

   always_comb begin
      if (alt_wide > ALT_HI) begin
         alt_sat = ALT_HI[COORD_WIDTH-1:0];
      end else if (alt_wide < ALT_LO) begin
         alt_sat = ALT_LO[COORD_WIDTH-1:0];
      end else begin
         alt_sat = alt_wide[COORD_WIDTH-1:0];
      end
   end

   // Datapath next values.
   always_comb begin
      glide_ratio_in = glide_ratio_ff;
      bank_sel_in    = bank_sel_ff;
      prev_x_in      = prev_x_ff;
      prev_y_in      = prev_y_ff;
      cur_alt_in     = cur_alt_ff;
      pt_x_in        = pt_x_ff;
      pt_y_in        = pt_y_ff;
      turn_in        = turn_ff;
      ax_in          = ax_ff;
      ay_in          = ay_ff;
      big_in         = big_ff;
      sum_in         = sum_ff;
      ratio_in       = ratio_ff;
      rem_in         = rem_ff;
      root_in        = root_ff;
      bit_in         = bit_ff;
      cnt_in         = cnt_ff;
      dist_in        = dist_ff;
      drem_in        = drem_ff;
      dq_in          = dq_ff;
      rsp_alt_in     = rsp_alt_ff;
      rsp_dist_in    = rsp_dist_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;

      if (csr_fire) begin
         unique case (csr_chan.index)
            REG_GLIDE_RATIO: glide_ratio_in = csr_chan.data[RATIO_W-1:0];
            REG_BANK_SEL:    bank_sel_in    = csr_chan.data[BANK_W-1:0];
            default:         glide_ratio_in = glide_ratio_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               dist_in = '0;
               pt_x_in = req_chan.point_x;
               pt_y_in = req_chan.point_y;
               turn_in = (req_chan.action == ACT_TURN);
               if (req_chan.action == ACT_START) begin
                  prev_x_in  = req_chan.point_x;
                  prev_y_in  = req_chan.point_y;
                  cur_alt_in = req_chan.entry_altitude;
               end
            end
         end
         S_DIFF: begin
            ax_in  = magx[31:0];
            ay_in  = magy[31:0];
            big_in = (magx[63:32] != '0) || (magy[63:32] != '0);
         end
         S_MULY: sum_in = {1'b0, mul_q};
         S_MULR: sum_in = sum_ff + {1'b0, mul_q};
         S_SUM: begin
            ratio_in = mul_q[31:0];
            dist_in  = '1;
            rem_in   = sum_ff[63:0];
            root_in  = '0;
            bit_in   = 64'(1) << 62;
            cnt_in   = CNT_W'(SQRT_STEPS);
         end
         S_SQRT: begin
            if (sub_ge) begin
               rem_in  = sub_diff;
               root_in = (root_ff >> 1) | bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            cnt_in  = cnt_ff - 1'b1;
            dist_in = root_in[DIST_W-1:0];
         end
         S_DIVI: begin
            dq_in   = {dist_ff, 24'b0};
            drem_in = '0;
            cnt_in  = CNT_W'(DIV_STEPS);
         end
         S_DIV: begin
            drem_in = sub_ge ? sub_diff[31:0] : sub_a[31:0];
            dq_in   = {dq_ff[54:0], sub_ge};
            cnt_in  = cnt_ff - 1'b1;
         end
         S_ALT: begin
            cur_alt_in = alt_sat;
            prev_x_in  = pt_x_ff;
            prev_y_in  = pt_y_ff;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_alt_in   = cur_alt_ff;
               rsp_dist_in  = dist_ff;
            end
         end
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         glide_ratio_ff <= GLIDE_RATIO_RESET;
         bank_sel_ff    <= BANK_SEL_RESET;
         prev_x_ff      <= '0;
         prev_y_ff      <= '0;
         cur_alt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         glide_ratio_ff <= glide_ratio_in;
         bank_sel_ff    <= bank_sel_in;
         prev_x_ff      <= prev_x_in;
         prev_y_ff      <= prev_y_in;
         cur_alt_ff     <= cur_alt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pt_x_ff     <= pt_x_in;
      pt_y_ff     <= pt_y_in;
      turn_ff     <= turn_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      big_ff      <= big_in;
      sum_ff      <= sum_in;
      ratio_ff    <= ratio_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      cnt_ff      <= cnt_in;
      dist_ff     <= dist_in;
      drem_ff     <= drem_in;
      dq_ff       <= dq_in;
      rsp_alt_ff  <= rsp_alt_in;
      rsp_dist_ff <= rsp_dist_in;
   end
endmodule

// File: sv/gaa_checker.sv
// ----------------------------------------------------------------------------
// Glide altitude accumulator checker
// Port-level assertions, attached to the top level by a bind.
// ----------------------------------------------------------------------------
`include "glide_altitude_accumulator_assert.svh"

module gaa_checker #(
   parameter int COORD_WIDTH = 32
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [COORD_WIDTH-1:0] rsp_altitude,
   input logic [31:0]            rsp_distance
);
   `GAA_ASSERT_ALWAYS(a_reset_drops_rsp, clock, reset |=> !rsp_valid)

   // Once a point is accepted, the block is busy and stops taking points.
   `GAA_ASSERT(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready)

   // A new result shows up only when the block has freed up for the next point.
   `GAA_ASSERT(a_rsp_frees_req, clock, reset, $rose(rsp_valid) |-> req_ready)

   `GAA_ASSERT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_altitude) && $stable(rsp_distance))
endmodule

bind glide_altitude_accumulator gaa_checker #(.COORD_WIDTH(COORD_WIDTH)) u_gaa_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_altitude (rsp_chan.altitude),
   .rsp_distance (rsp_chan.distance_step)
);
